[rtl/core/dcps_pkg.sv]
// dcps_pkg: shared types and constants for the distributed clock pi sync block
// no dependencies; used by dc_clock_pi_sync
`default_nettype none

package dcps_pkg;

   localparam int REF_WIDTH   = 63;
   localparam int CYCLE_WIDTH = 30;
   localparam int OUT_WIDTH   = 28;
   localparam int ERR_WIDTH   = 31;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int SYNC_OFFSET_NS = 50000;
   localparam int OFFSET_WIDTH   = 17;
   localparam int PROP_DIV       = 100;
   localparam int PROP_DIV_W     = 7;
   localparam int INT_DIV        = 20;
   localparam int INT_DIV_W      = 5;
   localparam int CYCLE_RESET    = 1000000;

   localparam int OUT_MAX = 2 ** (OUT_WIDTH - 1) - 1;
   localparam int OUT_MIN = -(2 ** (OUT_WIDTH - 1));

   // register index taken from paddr above the byte lanes
   localparam logic REG_CYCLE_TIME = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_FOLD,
      ST_INT,
      ST_IDIV,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

[rtl/core/dcps_serdiv.sv]
// dcps_serdiv: restoring divider, one quotient bit per cycle
// gives quotient and remainder of an unsigned dividend; uses no package items
`default_nettype none

module dcps_serdiv #(
   parameter int W  = 63,
   parameter int DW = 30
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [W-1:0]  dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               busy,
   output logic [W-1:0]       quotient,
   output logic [DW-1:0]      remainder
);

   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic [DW:0]      trial;
   logic [DW:0]      diff;
   logic             fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[W-1]};
      diff   = trial - {1'b0, divisor};
      // remainder stays below divisor, so the top bit is the borrow
      fits   = ~diff[DW];
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(W);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[W-2:0], fits};
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         run_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign busy      = run_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[rtl/core/dc_clock_pi_sync.sv]
// dc_clock_pi_sync: pi phase lock of a local clock to a distributed reference clock
// depends on dcps_pkg and dcps_serdiv
`default_nettype none

// Each item carries one reference time in ns and yields one signed correction in ns.
// The phase error is (ref_time - 50 us) rem cycle_time_ns (truncating, so it takes the
// sign of the difference), folded by one cycle when above half a cycle; an integral
// counter steps by one toward the error sign and saturates at INTEGRAL_WIDTH bits.
// The correction is -(error/100) - (integral/20), truncating, clamped to 28 bits.
// One item is in flight at a time: a bit-serial remainder, one fold step, the
// integral update, then the bit-serial divide of the integral by 20, overlapping
// the bit-serial divide of the error by 100.
// A finished result sits in the output register while the next item is accepted.
// cycle_time_ns sits at byte address 0; a value of 0 acts as 1.

module dc_clock_pi_sync #(
   parameter int INTEGRAL_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [dcps_pkg::REF_WIDTH-1:0]       req_ref_time,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [dcps_pkg::OUT_WIDTH-1:0]     rsp_correction_ns,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [dcps_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [dcps_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [dcps_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                      pready
);

   localparam int IW  = INTEGRAL_WIDTH;
   localparam int RW  = dcps_pkg::REF_WIDTH;
   localparam int CW  = dcps_pkg::CYCLE_WIDTH;
   localparam int EW  = dcps_pkg::ERR_WIDTH;
   localparam int OW  = dcps_pkg::OUT_WIDTH;
   localparam int SW  = (IW > CW ? IW : CW) + 2;

   localparam logic signed [IW-1:0] I_MAX = {1'b0, {(IW - 1){1'b1}}};
   localparam logic signed [IW-1:0] I_MIN = {1'b1, {(IW - 1){1'b0}}};
   localparam logic signed [SW-1:0] S_MAX = SW'(dcps_pkg::OUT_MAX);
   localparam logic signed [SW-1:0] S_MIN = SW'(dcps_pkg::OUT_MIN);
   localparam logic [RW-1:0] OFFSET_REF = RW'(dcps_pkg::SYNC_OFFSET_NS);
   localparam logic [dcps_pkg::OFFSET_WIDTH-1:0] OFFSET_NARROW =
      dcps_pkg::OFFSET_WIDTH'(dcps_pkg::SYNC_OFFSET_NS);

   dcps_pkg::state_type state_ff, state_in;

   logic [CW-1:0]          cycle_ff, cycle_in;
   logic [CW-1:0]          cyc_eff;
   logic                   neg_ff, neg_in;
   logic signed [EW-1:0]   err_ff, err_in;
   logic signed [IW-1:0]   integral_ff, integral_in;
   logic signed [SW-1:0]   sum_ff, sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0]   rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   csr_write;
   logic                   below_offset;
   logic [RW-1:0]          mod_dividend;
   logic                   mod_start, pdiv_start, idiv_start;
   logic                   mod_busy, pdiv_busy, idiv_busy;
   logic [RW-1:0]          mod_quo;
   logic [CW-1:0]          mod_rem;
   logic [CW-1:0]          perr_abs;
   logic [CW-1:0]          pdiv_quo;
   logic [dcps_pkg::PROP_DIV_W-1:0] pdiv_rem;
   logic [IW-1:0]          int_abs;
   logic [IW-1:0]          idiv_quo;
   logic [dcps_pkg::INT_DIV_W-1:0]  idiv_rem;
   logic signed [EW-1:0]   err_raw;
   logic signed [EW-1:0]   half_cyc;
   logic signed [SW-1:0]   prop_term, int_term;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[dcps_pkg::CSR_ADDR_W-1] == dcps_pkg::REG_CYCLE_TIME)
                      ? dcps_pkg::CSR_DATA_W'(cycle_ff) : '0;

   always_comb begin
      cycle_in = cycle_ff;
      if (csr_write && paddr[dcps_pkg::CSR_ADDR_W-1] == dcps_pkg::REG_CYCLE_TIME) begin
         cycle_in = pwdata[CW-1:0];
      end
   end

   assign cyc_eff = (cycle_ff == '0) ? CW'(1) : cycle_ff;

   // magnitude of ref - offset; below the offset it is small
   assign below_offset = req_ref_time < OFFSET_REF;
   assign mod_dividend = below_offset
                         ? RW'(OFFSET_NARROW - req_ref_time[dcps_pkg::OFFSET_WIDTH-1:0])
                         : req_ref_time - OFFSET_REF;

   assign accept = req_valid && !req_stall;

   dcps_serdiv #(.W(RW), .DW(CW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (cyc_eff),
      .busy      (mod_busy),
      .quotient  (mod_quo),
      .remainder (mod_rem)
   );

   assign perr_abs = err_ff[EW-1] ? CW'(-err_ff) : CW'(err_ff);

   dcps_serdiv #(.W(CW), .DW(dcps_pkg::PROP_DIV_W)) u_pdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (pdiv_start),
      .dividend  (perr_abs),
      .divisor   (dcps_pkg::PROP_DIV_W'(dcps_pkg::PROP_DIV)),
      .busy      (pdiv_busy),
      .quotient  (pdiv_quo),
      .remainder (pdiv_rem)
   );

   // the most negative integral maps to its own unsigned magnitude
   assign int_abs = integral_ff[IW-1] ? IW'(-integral_ff) : IW'(integral_ff);

   dcps_serdiv #(.W(IW), .DW(dcps_pkg::INT_DIV_W)) u_idiv (
      .clock     (clock),
      .reset     (reset),
      .start     (idiv_start),
      .dividend  (int_abs),
      .divisor   (dcps_pkg::INT_DIV_W'(dcps_pkg::INT_DIV)),
      .busy      (idiv_busy),
      .quotient  (idiv_quo),
      .remainder (idiv_rem)
   );

   always_comb begin
      err_raw   = neg_ff ? -$signed(EW'(mod_rem)) : $signed(EW'(mod_rem));
      half_cyc  = $signed(EW'(cyc_eff >> 1));
      prop_term = err_ff[EW-1] ? $signed(SW'(pdiv_quo)) : -$signed(SW'(pdiv_quo));
      int_term  = integral_ff[IW-1] ? $signed(SW'(idiv_quo)) : -$signed(SW'(idiv_quo));
   end

   always_comb begin
      state_in     = state_ff;
      req_stall    = (state_ff != dcps_pkg::ST_IDLE);
      mod_start    = 1'b0;
      pdiv_start   = 1'b0;
      idiv_start   = 1'b0;
      neg_in       = neg_ff;
      err_in       = err_ff;
      integral_in  = integral_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         dcps_pkg::ST_IDLE: begin
            if (req_valid) begin
               mod_start = 1'b1;
               neg_in    = below_offset;
               state_in  = dcps_pkg::ST_MOD;
            end
         end
         dcps_pkg::ST_MOD: begin
            if (!mod_busy) begin
               err_in   = err_raw;
               state_in = dcps_pkg::ST_FOLD;
            end
         end
         dcps_pkg::ST_FOLD: begin
            if (err_ff > half_cyc) begin
               err_in = err_ff - $signed(EW'(cyc_eff));
            end
            state_in = dcps_pkg::ST_INT;
         end
         dcps_pkg::ST_INT: begin
            priority if (err_ff > 0 && integral_ff != I_MAX) begin
               integral_in = integral_ff + IW'(1);
            end else if (err_ff < 0 && integral_ff != I_MIN) begin
               integral_in = integral_ff - IW'(1);
            end
            pdiv_start = 1'b1;
            state_in   = dcps_pkg::ST_IDIV;
         end
         dcps_pkg::ST_IDIV: begin
            idiv_start = 1'b1;
            state_in   = dcps_pkg::ST_DIV;
         end
         dcps_pkg::ST_DIV: begin
            if (!pdiv_busy && !idiv_busy) begin
               sum_in   = prop_term + int_term;
               state_in = dcps_pkg::ST_OUT;
            end
         end
         dcps_pkg::ST_OUT: begin
            // wait for the output register to free up
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               priority if (sum_ff > S_MAX) begin
                  rsp_data_in = OW'(S_MAX);
               end else if (sum_ff < S_MIN) begin
                  rsp_data_in = OW'(S_MIN);
               end else begin
                  rsp_data_in = OW'(sum_ff);
               end
               state_in = dcps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dcps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dcps_pkg::ST_IDLE;
         cycle_ff     <= CW'(dcps_pkg::CYCLE_RESET);
         integral_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cycle_ff     <= cycle_in;
         integral_ff  <= integral_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      err_ff      <= err_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_correction_ns = rsp_data_ff;

`ifndef SYNTHESIS
   a_accept_starts_mod: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == dcps_pkg::ST_MOD) && mod_busy)
      else $error("accepted item did not start the remainder");

   a_rem_below_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dcps_pkg::ST_MOD) && !mod_busy |-> mod_rem < cyc_eff)
      else $error("remainder not below cycle time");

   a_integral_only_in_int: assert property (@(posedge clock) disable iff (reset)
      state_ff != dcps_pkg::ST_INT |=> $stable(integral_ff))
      else $error("integral moved outside its update step");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dcps_pkg::ST_OUT) && !(rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("finished item not presented");
`endif

endmodule

`default_nettype wire
